>>> hw/rtl/ctd_pkg.sv
// Package for the chunked transfer decoder: widths, status codes, byte
// constants and the hex digit decode. No dependencies.
`default_nettype none

package ctd_pkg;

  // Width of the chunk size counter
  localparam int SIZE_BITS = 32;
  localparam int LIMIT_BITS = 32;
  localparam int CMP_BITS = (SIZE_BITS > LIMIT_BITS) ? SIZE_BITS : LIMIT_BITS;

  localparam logic [2:0] ST_FRAME   = 3'd0;
  localparam logic [2:0] ST_DATA    = 3'd1;
  localparam logic [2:0] ST_DONE    = 3'd2;
  localparam logic [2:0] ST_ERROR   = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] body_byte;
  } out_word_t;

  // Returns {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ctd_ifs.sv
// Valid/ready channel interfaces of the chunked transfer decoder.
// Depends on ctd_pkg.
`default_nettype none

interface ctd_in_if import ctd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;
  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface ctd_out_if import ctd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] body_byte;
  modport source (output valid, output status, output body_byte, input ready);
  modport sink (input valid, input status, input body_byte, output ready);
endinterface

interface ctd_cfg_if import ctd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [LIMIT_BITS-1:0] max_chunk_size;
  modport source (output valid, output max_chunk_size, input ready);
  modport sink (input valid, input max_chunk_size, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ctd_in_reg.sv
// Input register of the chunked transfer decoder: holds one accepted word.
// Depends on ctd_pkg.
`default_nettype none

module ctd_in_reg import ctd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_word,
  input  wire logic     advance,
  output logic          held_valid,
  output in_word_t      held_word
);

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;

  // Take a new word when empty or when the held word moves on this cycle
  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = in_valid || (valid_r && !advance);
  assign held_valid = valid_r;
  assign held_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ctd_parser.sv
// Chunk framing parser: parse state, size counter, size limit register and
// the per-byte status decode. Depends on ctd_pkg.
`default_nettype none

module ctd_parser import ctd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire in_word_t              word,
  input  wire logic                  cfg_we,
  input  wire logic [LIMIT_BITS-1:0] cfg_limit,
  output out_word_t                  result
);

  localparam logic [3:0] M_SIZE       = 4'd0;
  localparam logic [3:0] M_EXT        = 4'd1;
  localparam logic [3:0] M_SIZE_LF    = 4'd2;
  localparam logic [3:0] M_EXT_LF     = 4'd3;
  localparam logic [3:0] M_DATA       = 4'd4;
  localparam logic [3:0] M_DATA_CR    = 4'd5;
  localparam logic [3:0] M_DATA_LF    = 4'd6;
  localparam logic [3:0] M_TRAILER    = 4'd7;
  localparam logic [3:0] M_TRAILER_LF = 4'd8;
  localparam logic [3:0] M_DONE       = 4'd9;
  localparam logic [3:0] M_ERROR      = 4'd10;

  logic [3:0]            mode_r, mode_nxt, mode_e;
  logic [SIZE_BITS-1:0]  cnt_r, cnt_nxt, cnt_e;
  logic                  digit_r, digit_nxt, digit_e;
  logic                  ne_r, ne_nxt, ne_e;
  logic                  colon_r, colon_nxt, colon_e;
  logic [LIMIT_BITS-1:0] limit_r;

  logic [7:0]           b;
  logic [4:0]           hex;
  logic [SIZE_BITS-1:0] cnt_shift;
  logic [SIZE_BITS-1:0] cnt_dec;
  logic                 cnt_ovf;
  logic                 too_big;
  logic [2:0]           st;
  logic [7:0]           body;

  assign b = word.data_byte;

  // Restart acts before the byte is handled
  assign mode_e  = word.restart ? M_SIZE : mode_r;
  assign cnt_e   = word.restart ? '0 : cnt_r;
  assign digit_e = word.restart ? 1'b0 : digit_r;
  assign ne_e    = word.restart ? 1'b0 : ne_r;
  assign colon_e = word.restart ? 1'b0 : colon_r;

  assign hex       = hex_decode(b);
  assign cnt_ovf   = cnt_e[SIZE_BITS-1 -: 4] != 4'd0;
  assign cnt_shift = {cnt_e[SIZE_BITS-5:0], hex[3:0]};
  assign too_big   = CMP_BITS'(cnt_shift) > CMP_BITS'(limit_r);
  assign cnt_dec   = cnt_e - SIZE_BITS'(1);

  always_comb begin
    mode_nxt  = mode_e;
    cnt_nxt   = cnt_e;
    digit_nxt = digit_e;
    ne_nxt    = ne_e;
    colon_nxt = colon_e;
    st        = ST_FRAME;
    body      = 8'd0;
    case (mode_e)
      M_SIZE: begin
        if (hex[4]) begin
          if (cnt_ovf) begin
            mode_nxt = M_ERROR;
            st       = ST_ERROR;
          end else begin
            cnt_nxt   = cnt_shift;
            digit_nxt = 1'b1;
            if (too_big) begin
              mode_nxt = M_ERROR;
              st       = ST_ERROR;
            end
          end
        end else if (b == CH_SPACE || b == CH_SEMI) begin
          mode_nxt = M_EXT;
        end else if (b == CH_CR) begin
          mode_nxt = M_SIZE_LF;
        end else begin
          mode_nxt = M_ERROR;
          st       = ST_ERROR;
        end
      end
      M_EXT: begin
        if (b == CH_CR) mode_nxt = M_EXT_LF;
      end
      M_SIZE_LF, M_EXT_LF: begin
        if (mode_e == M_EXT_LF && b != CH_LF) begin
          // bare CR in an extension is line content
          if (b != CH_CR) mode_nxt = M_EXT;
        end else if (b != CH_LF || !digit_e) begin
          mode_nxt = M_ERROR;
          st       = ST_ERROR;
        end else if (cnt_e != '0) begin
          mode_nxt = M_DATA;
        end else begin
          mode_nxt  = M_TRAILER;
          ne_nxt    = 1'b0;
          colon_nxt = 1'b0;
        end
      end
      M_DATA: begin
        st      = ST_DATA;
        body    = b;
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) mode_nxt = M_DATA_CR;
      end
      M_DATA_CR: begin
        if (b == CH_CR) begin
          mode_nxt = M_DATA_LF;
        end else begin
          mode_nxt = M_ERROR;
          st       = ST_ERROR;
        end
      end
      M_DATA_LF: begin
        if (b == CH_LF) begin
          mode_nxt  = M_SIZE;
          cnt_nxt   = '0;
          digit_nxt = 1'b0;
          ne_nxt    = 1'b0;
          colon_nxt = 1'b0;
        end else begin
          mode_nxt = M_ERROR;
          st       = ST_ERROR;
        end
      end
      M_TRAILER, M_TRAILER_LF: begin
        if (mode_e == M_TRAILER_LF && b == CH_LF) begin
          if (!ne_e) begin
            mode_nxt = M_DONE;
            st       = ST_DONE;
          end else if (!colon_e) begin
            mode_nxt = M_ERROR;
            st       = ST_ERROR;
          end else begin
            mode_nxt  = M_TRAILER;
            ne_nxt    = 1'b0;
            colon_nxt = 1'b0;
          end
        end else begin
          // a held CR followed by anything but LF makes the line non-empty
          if (mode_e == M_TRAILER_LF) ne_nxt = 1'b1;
          if (b == CH_CR) begin
            mode_nxt = M_TRAILER_LF;
          end else begin
            mode_nxt = M_TRAILER;
            ne_nxt   = 1'b1;
            if (b == CH_COLON) colon_nxt = 1'b1;
          end
        end
      end
      M_DONE: begin
        st = ST_IGNORED;
      end
      default: begin
        mode_nxt = M_ERROR;
        st       = ST_ERROR;
      end
    endcase
  end

  assign result = '{status: st, body_byte: body};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_SIZE;
      cnt_r   <= '0;
      digit_r <= 1'b0;
      ne_r    <= 1'b0;
      colon_r <= 1'b0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      digit_r <= digit_nxt;
      ne_r    <= ne_nxt;
      colon_r <= colon_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '1;
    end else if (cfg_we) begin
      limit_r <= cfg_limit;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/chunked_transfer_decoder_core.sv
// Chunked transfer decoder, one status word per input byte.
// A word accepted into the input register is decoded, and the result is
// registered in the output register that drives the result channel.
// Throughput: one byte per cycle while the result channel does not stall.
// Reset (rst_n low, synchronous): channels empty, parser expects a size
// line, size limit returns to all ones. Depends on ctd_pkg, ctd_ifs.
`default_nettype none

module chunked_transfer_decoder_core import ctd_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  ctd_in_if.sink    in_if,
  ctd_out_if.source out_if,
  ctd_cfg_if.sink   cfg_if
);

  in_word_t  in_word;
  in_word_t  held_word;
  logic      held_valid;
  logic      advance;
  out_word_t result;
  out_word_t out_r;
  logic      out_valid_r;
  logic      out_valid_nxt;

  assign in_word = '{data_byte: in_if.data_byte, restart: in_if.restart};

  // Move the held word into the result register when that slot frees up
  assign advance       = held_valid && (!out_valid_r || out_if.ready);
  assign out_valid_nxt = advance || (out_valid_r && !out_if.ready);

  ctd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_word    (in_word),
    .advance    (advance),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  ctd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .word      (held_word),
    .cfg_we    (cfg_if.valid),
    .cfg_limit (cfg_if.max_chunk_size),
    .result    (result)
  );

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.status    = out_r.status;
  assign out_if.body_byte = out_r.body_byte;

endmodule

`default_nettype wire

>>> tb/tb_chunked_transfer_decoder_core.sv
`timescale 1ns / 1ps
// Testbench for chunked_transfer_decoder_core: drives chunked body bytes and
// checks every status word against an in-bench decoder model.
// Depends on ctd_pkg, ctd_ifs and the core RTL.

module tb_chunked_transfer_decoder_core;
  import ctd_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;

  typedef enum logic [3:0] {
    P_SIZE, P_EXT, P_SIZE_LF, P_EXT_LF, P_DATA, P_DATA_CR, P_DATA_LF,
    P_TRAILER, P_TRAILER_LF, P_DONE, P_ERROR
  } parse_mode_t;

  typedef struct {
    logic [2:0] status;
    logic [7:0] body_byte;
  } status_word_t;

  logic clk;
  logic rst_n;

  ctd_in_if  in_ch ();
  ctd_out_if out_ch ();
  ctd_cfg_if cfg_ch ();

  chunked_transfer_decoder_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Decoder model state
  parse_mode_t           pmode;
  logic [SIZE_BITS-1:0]  size_cnt;
  logic                  got_digit;
  logic                  line_has_text;
  logic                  line_has_colon;
  logic [LIMIT_BITS-1:0] size_limit;

  status_word_t pending_status_q[$];
  int mismatches;
  int bytes_sent;
  int idle_cycles;
  int recv_stall_left;
  int recv_wait;
  bit send_gaps_off;
  bit recv_gaps_off;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int pick_gap(input bit off);
    int r;
    r = $urandom_range(0, 99);
    if (off || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int nibble_of(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
    return -1;
  endfunction

  function automatic void clear_parser();
    pmode = P_SIZE;
    size_cnt = '0;
    got_digit = 1'b0;
    line_has_text = 1'b0;
    line_has_colon = 1'b0;
  endfunction

  function automatic logic [2:0] enter_error();
    pmode = P_ERROR;
    return ST_ERROR;
  endfunction

  function automatic logic [2:0] close_size_line(input logic [7:0] b);
    if (b != CH_LF || !got_digit) return enter_error();
    if (size_cnt != '0) begin
      pmode = P_DATA;
    end else begin
      pmode = P_TRAILER;
      line_has_text = 1'b0;
      line_has_colon = 1'b0;
    end
    return ST_FRAME;
  endfunction

  function automatic logic [2:0] take_trailer_char(input logic [7:0] b);
    if (b == CH_CR) begin
      pmode = P_TRAILER_LF;
    end else begin
      pmode = P_TRAILER;
      line_has_text = 1'b1;
      if (b == CH_COLON) line_has_colon = 1'b1;
    end
    return ST_FRAME;
  endfunction

  // Advance the decoder model by one byte and return its status word
  function automatic status_word_t decode_byte(input logic [7:0] b, input logic rs);
    status_word_t r;
    int d;
    r.status = ST_FRAME;
    r.body_byte = 8'h00;
    if (rs) clear_parser();
    case (pmode)
      P_SIZE: begin
        d = nibble_of(b);
        if (d >= 0) begin
          if (size_cnt[SIZE_BITS-1 -: 4] != 4'h0) begin
            r.status = enter_error();
          end else begin
            size_cnt = {size_cnt[SIZE_BITS-5:0], 4'(d)};
            got_digit = 1'b1;
            if (size_cnt > size_limit) r.status = enter_error();
          end
        end else if (b == CH_SPACE || b == CH_SEMI) begin
          pmode = P_EXT;
        end else if (b == CH_CR) begin
          pmode = P_SIZE_LF;
        end else begin
          r.status = enter_error();
        end
      end
      P_EXT: begin
        if (b == CH_CR) pmode = P_EXT_LF;
      end
      P_SIZE_LF: r.status = close_size_line(b);
      P_EXT_LF: begin
        if (b == CH_LF) r.status = close_size_line(b);
        else if (b != CH_CR) pmode = P_EXT;
      end
      P_DATA: begin
        r.status = ST_DATA;
        r.body_byte = b;
        size_cnt = size_cnt - 1'b1;
        if (size_cnt == '0) pmode = P_DATA_CR;
      end
      P_DATA_CR: begin
        if (b == CH_CR) pmode = P_DATA_LF;
        else r.status = enter_error();
      end
      P_DATA_LF: begin
        if (b == CH_LF) clear_parser();
        else r.status = enter_error();
      end
      P_TRAILER: r.status = take_trailer_char(b);
      P_TRAILER_LF: begin
        if (b == CH_LF) begin
          if (!line_has_text) begin
            pmode = P_DONE;
            r.status = ST_DONE;
          end else if (!line_has_colon) begin
            r.status = enter_error();
          end else begin
            pmode = P_TRAILER;
            line_has_text = 1'b0;
            line_has_colon = 1'b0;
          end
        end else begin
          line_has_text = 1'b1;
          r.status = take_trailer_char(b);
        end
      end
      P_DONE: r.status = ST_IGNORED;
      default: r.status = enter_error();
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  // Send one word; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic rs);
    int gap;
    gap = pick_gap(send_gaps_off);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.restart <= rs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_status_q.push_back(decode_byte(b, rs));
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic rs_first);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], rs_first && i == 0);
  endtask

  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_chunk_size <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    size_limit = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] text_char();
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  task automatic add_size_line(ref logic [7:0] m[$], input int size);
    string s;
    logic [7:0] c;
    s = $sformatf("%0h", size);
    repeat ($urandom_range(0, 2)) m.push_back(8'h30);
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= 8'h61 && $urandom_range(0, 1)) c = c - 8'h20;
      m.push_back(c);
    end
    if ($urandom_range(0, 3) == 0) begin
      m.push_back($urandom_range(0, 1) ? CH_SPACE : CH_SEMI);
      repeat ($urandom_range(0, 4)) m.push_back(text_char());
      // bare CR inside the extension stays line content
      if ($urandom_range(0, 2) == 0) begin
        m.push_back(CH_CR);
        m.push_back(text_char());
      end
    end
    m.push_back(CH_CR);
    m.push_back(CH_LF);
  endtask

  task automatic build_message(ref logic [7:0] m[$]);
    int size;
    repeat ($urandom_range(0, 3)) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      add_size_line(m, size);
      repeat (size) m.push_back(8'($urandom_range(0, 255)));
      m.push_back(CH_CR);
      m.push_back(CH_LF);
    end
    add_size_line(m, 0);
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 3)) m.push_back(text_char());
      m.push_back(CH_COLON);
      repeat ($urandom_range(0, 3)) m.push_back(text_char());
      if ($urandom_range(0, 6) == 0) begin
        m.push_back(CH_CR);
        m.push_back(text_char());
      end
      m.push_back(CH_CR);
      m.push_back(CH_LF);
    end
    m.push_back(CH_CR);
    m.push_back(CH_LF);
  endtask

  task automatic send_random_message();
    logic [7:0] m[$];
    logic rs;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) m.push_back(8'($urandom_range(0, 255)));
    end else begin
      build_message(m);
      // break some messages: one byte replaced, or the tail dropped
      if ($urandom_range(0, 99) < 15) begin
        m[$urandom_range(0, m.size() - 1)] = 8'($urandom_range(0, 255));
      end else if ($urandom_range(0, 99) < 6) begin
        m = m[0:$urandom_range(0, m.size() - 1)];
      end
    end
    rs = ($urandom_range(0, 99) < 85);
    foreach (m[k]) send_byte(m[k], (k == 0) ? rs : ($urandom_range(0, 99) == 0));
  endtask

  // Receiver: random ready, plus a long hold-off on request
  always @(negedge clk) begin
    if (recv_stall_left > 0) begin
      out_ch.ready <= 1'b0;
      recv_stall_left--;
    end else if (recv_wait > 0) begin
      out_ch.ready <= 1'b0;
      recv_wait--;
    end else begin
      out_ch.ready <= 1'b1;
      recv_wait = pick_gap(recv_gaps_off);
    end
  end

  always @(posedge clk) begin : check_results
    status_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_status_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word status=%0d body=%02h",
                                  out_ch.status, out_ch.body_byte));
      end else begin
        want = pending_status_q.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_ch.status, want.status));
        if (out_ch.body_byte !== want.body_byte)
          report_mismatch($sformatf("body_byte got %02h want %02h",
                                    out_ch.body_byte, want.body_byte));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // Full message at the reset limit: extension with a bare CR, data extremes,
  // trailer with a bare CR, completion, then an ignored byte
  task automatic test_framing();
    send_text("2;\015x\015\012", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("\015\0120\015\012a\015:\015\012\015\012Z", 1'b0);
    send_text("aB\015\012", 1'b1);
  endtask

  task automatic test_errors();
    send_text("g5", 1'b1);                   // bad size char, then sticky
    send_text("\015\012", 1'b1);             // size line without digits
    send_text("1\015X", 1'b1);               // CR not followed by LF
    send_text("1\015\012AB", 1'b1);          // no CR LF after data
    send_text("0\015\012ab\015\012", 1'b1);  // trailer line without colon
  endtask

  task automatic test_size_limits();
    logic [LIMIT_BITS-1:0] lim;
    wait_results_done();
    write_limit('0);
    send_text("0\015\012\015\012", 1'b1);
    send_text("1", 1'b1);
    wait_results_done();
    write_limit(32'd1);
    send_text("1\015\012", 1'b1);
    send_text("2", 1'b1);
    wait_results_done();
    lim = $urandom_range(2, 32'hFFFF_FFFE);
    write_limit(lim);
    send_text($sformatf("%0h\015\012", lim), 1'b1);
    send_text($sformatf("%0h", lim + 1'b1), 1'b1);
    wait_results_done();
    write_limit('1);
    send_text("FFFFFFFF\015\012", 1'b1);
    send_text("100000000", 1'b1);            // ninth digit overflows the counter
  endtask

  task automatic test_random_streams();
    int target;
    logic [LIMIT_BITS-1:0] lim;
    for (int ph = 0; ph < 6; ph++) begin
      wait_results_done();
      case (ph)
        1: lim = $urandom_range(1, 12);
        3: lim = 32'd1;
        4: lim = $urandom_range(13, 64);
        5: lim = $urandom();
        default: lim = '1;
      endcase
      write_limit(lim);
      send_gaps_off = (ph == 2 || ph == 4);
      recv_gaps_off = (ph == 2);
      if (ph == 4) begin
        // hold the receiver so the core fills up and stalls its input
        @(posedge clk);
        recv_stall_left = 150;
        @(negedge clk);
      end
      target = bytes_sent + 115;
      while (bytes_sent < target) send_random_message();
    end
    send_gaps_off = 1'b0;
    recv_gaps_off = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_chunk_size = '0;
    mismatches = 0;
    bytes_sent = 0;
    idle_cycles = 0;
    recv_stall_left = 0;
    recv_wait = 0;
    send_gaps_off = 1'b0;
    recv_gaps_off = 1'b0;
    size_limit = '1;
    clear_parser();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_framing();
    test_errors();
    test_size_limits();
    test_random_streams();

    wait_results_done();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
